### rtl/swnr_pkg.sv
package swnr_pkg;

    localparam logic [7:0] WINDOW    = 8'd3;
    localparam logic [8:0] WINDOW_P1 = {1'b0, WINDOW} + 9'd1;

    typedef struct packed {
        logic [7:0] expected_seq;
        logic [7:0] window_base;
        logic [7:0] in_window_count;
        logic [7:0] nack_ticks;
        logic       nack_pending;
    } state_t;

    typedef struct packed {
        logic [7:0] reply_seq;
        logic       send_nack;
        logic       send_ack;
        logic       accepted;
    } result_t;

    // saturate a start number into the sequence space
    function automatic logic [7:0] clamp_start(input logic [7:0] v);
        clamp_start = (v > WINDOW) ? WINDOW : v;
    endfunction

endpackage

### rtl/swnr_step.sv
module swnr_step (
    input  swnr_pkg::state_t  cur,
    input  logic [7:0]        recv_seq,
    output swnr_pkg::state_t  nxt,
    output swnr_pkg::result_t res
);

    logic [7:0] ticks_adv;
    logic [7:0] count_inc;
    logic [8:0] off_seq;
    logic [8:0] off_exp;
    logic       ahead;
    logic       pend;

    // offset ahead of the window base, modulo WINDOW+1
    function automatic logic [8:0] offset_from_base(input logic [7:0] v,
                                                    input logic [7:0] base);
        if (v >= base)
            offset_from_base = {1'b0, v} - {1'b0, base};
        else
            offset_from_base = {1'b0, v} + swnr_pkg::WINDOW_P1 - {1'b0, base};
    endfunction

    always_comb
    begin
        nxt = cur;
        res = '0;

        ticks_adv = (cur.nack_ticks >= swnr_pkg::WINDOW) ? 8'd0 : cur.nack_ticks + 8'd1;
        count_inc = cur.in_window_count + 8'd1;
        off_seq   = offset_from_base(recv_seq, cur.window_base);
        off_exp   = offset_from_base(cur.expected_seq, cur.window_base);
        // a number beyond the window never counts as ahead
        ahead     = (recv_seq <= swnr_pkg::WINDOW) && (off_seq > off_exp);
        pend      = cur.nack_pending || (cur.expected_seq == cur.window_base) || ahead;

        nxt.nack_ticks = ticks_adv;

        if (recv_seq == cur.expected_seq)
        begin
            res.accepted = 1'b1;
            if (count_inc >= swnr_pkg::WINDOW)
            begin
                // moving on by WINDOW is a step back by one
                nxt.window_base     = (cur.window_base == 8'd0) ? swnr_pkg::WINDOW
                                                                : cur.window_base - 8'd1;
                nxt.in_window_count = 8'd0;
                res.send_ack        = 1'b1;
                res.reply_seq       = recv_seq;
            end
            else
            begin
                nxt.in_window_count = count_inc;
            end
            nxt.expected_seq = (cur.expected_seq >= swnr_pkg::WINDOW) ? 8'd0
                                                                     : cur.expected_seq + 8'd1;
        end
        else
        begin
            nxt.nack_pending = pend;
            if ((ticks_adv == swnr_pkg::WINDOW) && pend)
            begin
                res.send_nack    = 1'b1;
                res.reply_seq    = cur.expected_seq;
                nxt.nack_pending = 1'b0;
                nxt.nack_ticks   = 8'd0;
            end
        end
    end

endmodule

### rtl/sliding_window_nack_receiver.sv
// Receiver side of a sliding-window transfer with negative acknowledgement.
// Slave stream: one word per received data packet, its sequence number.
// Master stream: one word per received packet: accepted flag, ACK flag, NACK
// flag and the reply number (the packet's number on an ACK, the expected
// number on a NACK, zero otherwise).
// cfg_we/cfg_wdata write the start number; it is saturated to the window
// size and loads the expected number and window base. Write only when idle.
// The reply is registered, via the skid stage when the output stalls.
// Throughput: one packet per cycle while the skid stage is empty; the whole step
// is a few modular compares and increments on the state registers.
// Reset clears all state to a start number of zero and empties the output.
// When the master side stalls, one more word is held in a skid stage and
// s_axis_tready drops until the output register drains.
module sliding_window_nack_receiver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] recv_seq
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [0] accepted, [1] send_ack, [2] send_nack,
                                        // [10:3] reply_seq, [15:11] zero
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);

    swnr_pkg::state_t  state_reg;
    swnr_pkg::state_t  state_next;
    swnr_pkg::result_t step_res;
    swnr_pkg::result_t out_reg;
    swnr_pkg::result_t skid_reg;
    logic              out_valid_reg;
    logic              skid_valid_reg;
    logic              in_take;
    logic              out_take;
    logic [7:0]        start_clamped;

    assign s_axis_tready = !skid_valid_reg;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign out_take      = out_valid_reg && m_axis_tready;
    assign m_axis_tdata  = {5'd0, out_reg};
    assign start_clamped = swnr_pkg::clamp_start(cfg_wdata);

    swnr_step u_step (
        .cur      (state_reg),
        .recv_seq (s_axis_tdata),
        .nxt      (state_next),
        .res      (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (cfg_we)
        begin
            state_reg.expected_seq <= start_clamped;
            state_reg.window_base  <= start_clamped;
        end
        else if (in_take)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            // drain the skid word into the output register
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_take)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (in_take)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_reg <= step_res;
            end
            else
            begin
                out_reg <= step_res;
            end
        end
    end

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held with empty output register");

    a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_axis_tready))
        else $error("skid stage filled without a stall");

    a_ack_nack_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.send_ack && out_reg.send_nack))
        else $error("ACK and NACK in one reply");

    a_ack_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.send_ack) |-> out_reg.accepted)
        else $error("ACK without an accepted packet");

    a_seq_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.expected_seq <= swnr_pkg::WINDOW)
        && (state_reg.window_base <= swnr_pkg::WINDOW)
        && (state_reg.in_window_count < swnr_pkg::WINDOW))
        else $error("window state out of range");

endmodule

### tb/sv/tb.sv
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] DIRECTED_SEQS [24] = '{
        8'd0, 8'd1, 8'd2, 8'd3, 8'd0, 8'd1, 8'd255, 8'd128,
        8'd4, 8'd1, 8'd3, 8'd2, 8'd0, 8'd2, 8'd2, 8'd2,
        8'd3, 8'd3, 8'd170, 8'd85, 8'd0, 8'd1, 8'd2, 8'd3};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;     // [7:0] recv_seq
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [15:0] m_axis_tdata;            // [0] accepted, [1] send_ack, [2] send_nack,
                                          // [10:3] reply_seq, [15:11] zero
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_wdata = 8'd0;

    // packet numbers waiting to be offered, and replies the receiver owes
    logic [7:0]        packets_to_send[$];
    swnr_pkg::result_t replies_due[$];

    // receiver state as predicted
    logic [7:0] exp_num;
    logic [7:0] base_num;
    logic [7:0] run_count;
    logic [7:0] tick_count;
    logic       nack_flag;

    int  src_idle_pct = 0;
    int  snk_idle_pct = 0;
    int  hold_reqs = 0;
    int  hold_done = 0;
    int  hold_left = 0;
    int  mismatch_total = 0;
    bit  seq_taken = 1'b0;
    logic [7:0] gen_exp = 8'd0;

    sliding_window_nack_receiver u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always #5ns clk = ~clk;

    function automatic logic [7:0] sat_start(input logic [7:0] v);
        return (v > swnr_pkg::WINDOW) ? swnr_pkg::WINDOW : v;
    endfunction

    // distance of a number ahead of the window base, wrapping at WINDOW+1
    function automatic int ahead(input logic [7:0] v);
        if (v >= base_num)
            return int'(v) - int'(base_num);
        return int'(v) + int'(swnr_pkg::WINDOW) + 1 - int'(base_num);
    endfunction

    function automatic swnr_pkg::result_t take_packet(input logic [7:0] seq);
        swnr_pkg::result_t r;
        r = '0;
        tick_count = (tick_count >= swnr_pkg::WINDOW) ? 8'd0 : tick_count + 8'd1;
        if (seq == exp_num)
        begin
            r.accepted = 1'b1;
            run_count = run_count + 8'd1;
            if (run_count >= swnr_pkg::WINDOW)
            begin
                // a step of WINDOW modulo WINDOW+1 is one step back
                base_num = (base_num == 8'd0) ? swnr_pkg::WINDOW : base_num - 8'd1;
                r.send_ack = 1'b1;
                r.reply_seq = seq;
                run_count = 8'd0;
            end
            exp_num = (exp_num >= swnr_pkg::WINDOW) ? 8'd0 : exp_num + 8'd1;
        end
        else
        begin
            if (exp_num == base_num)
                nack_flag = 1'b1;
            else if (seq <= swnr_pkg::WINDOW && ahead(seq) > ahead(exp_num))
                nack_flag = 1'b1;
            if (tick_count == swnr_pkg::WINDOW && nack_flag)
            begin
                r.send_nack = 1'b1;
                r.reply_seq = exp_num;
                nack_flag = 1'b0;
                tick_count = 8'd0;
            end
        end
        return r;
    endfunction

    task automatic check_reply(input swnr_pkg::result_t want, input swnr_pkg::result_t got);
        if (want !== got)
        begin
            $display("%0t: reply mismatch, expected %0h actual %0h", $time, want, got);
            mismatch_total++;
        end
    endtask

    // predict on every word taken in, check every word handed out
    always @(posedge clk or negedge rst_n)
    begin
        swnr_pkg::result_t want;
        swnr_pkg::result_t got;
        if (!rst_n)
        begin
            exp_num    = 8'd0;
            base_num   = 8'd0;
            run_count  = 8'd0;
            tick_count = 8'd0;
            nack_flag  = 1'b0;
            seq_taken <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                exp_num  = sat_start(cfg_wdata);
                base_num = sat_start(cfg_wdata);
            end
            seq_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
                replies_due.push_back(take_packet(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = swnr_pkg::result_t'(m_axis_tdata[10:0]);
                if (replies_due.size() == 0)
                begin
                    $display("%0t: unexpected reply, expected none actual %0h",
                             $time, m_axis_tdata);
                    mismatch_total++;
                end
                else
                begin
                    want = replies_due.pop_front();
                    check_reply(want, got);
                end
            end
        end
    end

    // sender: hold the word until taken, then offer the next or idle
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || seq_taken))
        begin
            if (packets_to_send.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= packets_to_send.pop_front();
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_reqs != hold_done)
        begin
            hold_done = hold_reqs;
            hold_left = 60;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    task automatic queue_seq(input logic [7:0] seq);
        packets_to_send.push_back(seq);
        if (seq == gen_exp)
            gen_exp = (gen_exp >= swnr_pkg::WINDOW) ? 8'd0 : gen_exp + 8'd1;
    endtask

    // mostly in-order traffic, with reordering, repeats and wild numbers
    task automatic queue_random(input int count);
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
                queue_seq(gen_exp);
            else if (pick < 88)
                queue_seq(8'($urandom_range(int'(swnr_pkg::WINDOW))));
            else
                queue_seq(8'($urandom_range(255)));
        end
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (packets_to_send.size() != 0 || s_axis_tvalid || replies_due.size() != 0);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_start(input logic [7:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        gen_exp = sat_start(v);
    endtask

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        src_idle_pct = 14;
        snk_idle_pct = 83;
        for (int i = 0; i < 24; i++)
            queue_seq(DIRECTED_SEQS[i]);
        drain();

        write_start(swnr_pkg::WINDOW);
        queue_random(150);
        // pause the sender until every reply is in
        drain();
        queue_random(150);
        drain();

        src_idle_pct = 83;
        snk_idle_pct = 14;
        write_start(8'd255);
        queue_random(300);
        drain();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        write_start(8'd1);
        hold_reqs++;
        queue_random(100);
        drain();
        write_start(8'd2);
        queue_random(80);
        drain();
        write_start(8'd0);
        queue_random(80);
        drain();
        write_start(8'($urandom_range(255)));
        queue_random(80);
        drain();

        repeat (10) @(negedge clk);
        if (mismatch_total == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
